// ----- design/sas_pkg.sv -----
// Shared types and constants for the sprite animation sequencer
`default_nettype none
package sas_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam logic [9:0] TILE_LIMIT = 10'h1FF;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_STEP  = 2'd2,
        OP_APPLY = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [7:0] duration;
        logic [8:0] tile;
        logic [7:0] xoff;
        logic [7:0] yoff;
        logic       hflip;
        logic       vflip;
    } frame_entry_t;

endpackage
`default_nettype wire

// ----- design/sas_frame_mem.sv -----
// Frame table: single-port-write, registered-read synchronous memory
`default_nettype none
module sas_frame_mem #(
    parameter int MAX_FRAMES = sas_pkg::MAX_FRAMES_DEF,
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic [IDX_W-1:0]            rd_addr,
    output sas_pkg::frame_entry_t            rd_data,
    input  wire logic                        wr_en,
    input  wire logic [IDX_W-1:0]            wr_addr,
    input  wire sas_pkg::frame_entry_t       wr_data
);

    sas_pkg::frame_entry_t mem [MAX_FRAMES];
    sas_pkg::frame_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- design/sas_core.sv -----
// Sequencer control: operation FSM, animation state, result register
`default_nettype none
module sas_core #(
    parameter int MAX_FRAMES = sas_pkg::MAX_FRAMES_DEF,
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [7:0]           frame_duration,
    input  wire logic [9:0]           frame_tile,
    input  wire logic signed [7:0]    frame_x_offset,
    input  wire logic signed [7:0]    frame_y_offset,
    input  wire logic                 frame_hflip,
    input  wire logic                 frame_vflip,
    input  wire logic signed [15:0]   base_x,
    input  wire logic [7:0]           base_y,
    input  wire logic                 base_hflip,
    input  wire logic                 base_vflip,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      ok,
    output logic signed [15:0]        sprite_x,
    output logic [7:0]                sprite_y,
    output logic [8:0]                sprite_tile,
    output logic                      sprite_hflip,
    output logic                      sprite_vflip,
    output logic                      finished_flag,
    output logic                      mem_rd_en,
    output logic [IDX_W-1:0]          mem_rd_addr,
    input  wire sas_pkg::frame_entry_t mem_rd_data,
    output logic                      mem_wr_en,
    output logic [IDX_W-1:0]          mem_wr_addr,
    output sas_pkg::frame_entry_t     mem_wr_data
);

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    sas_pkg::state_t state_reg, state_next;
    logic             loop_mode_reg;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [7:0]       tick_reg, tick_next;
    logic             done_reg, done_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    // latched input item
    sas_pkg::op_t     op_reg;
    logic [7:0]       dur_reg;
    logic [9:0]       tile_reg;
    logic [7:0]       xoff_reg;
    logic [7:0]       yoff_reg;
    logic             fh_reg;
    logic             fv_reg;
    logic [15:0]      bx_reg;
    logic [7:0]       by_reg;
    logic             bh_reg;
    logic             bv_reg;

    // result register
    logic             ok_reg, ok_next;
    logic [15:0]      sx_reg, sx_next;
    logic [7:0]       sy_reg, sy_next;
    logic [8:0]       st_reg, st_next;
    logic             shf_reg, shf_next;
    logic             svf_reg, svf_next;
    logic             fin_reg;

    logic             accept;
    logic [7:0]       tick_inc;
    logic [CNT_W-1:0] cur_inc;

    assign accept   = in_valid && (state_reg == sas_pkg::ST_IDLE);
    assign in_stall = (state_reg != sas_pkg::ST_IDLE);

    assign mem_rd_en   = accept;
    assign mem_rd_addr = cur_reg;
    assign mem_wr_addr = IDX_W'(total_reg);
    assign mem_wr_data = '{duration: dur_reg, tile: tile_reg[8:0], xoff: xoff_reg,
                           yoff: yoff_reg, hflip: fh_reg, vflip: fv_reg};

    assign tick_inc = tick_reg + 8'd1;
    assign cur_inc  = CNT_W'(cur_reg) + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sas_pkg::ST_IDLE;
            loop_mode_reg <= 1'b0;
            total_reg     <= '0;
            cur_reg       <= '0;
            tick_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            tick_reg      <= tick_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                loop_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= sas_pkg::op_t'(operation);
            dur_reg  <= frame_duration;
            tile_reg <= frame_tile;
            xoff_reg <= frame_x_offset;
            yoff_reg <= frame_y_offset;
            fh_reg   <= frame_hflip;
            fv_reg   <= frame_vflip;
            bx_reg   <= base_x;
            by_reg   <= base_y;
            bh_reg   <= base_hflip;
            bv_reg   <= base_vflip;
        end
        if (out_load)
        begin
            ok_reg  <= ok_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            st_reg  <= st_next;
            shf_reg <= shf_next;
            svf_reg <= svf_next;
            fin_reg <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        cur_next   = cur_reg;
        tick_next  = tick_reg;
        done_next  = done_reg;
        out_load   = 1'b0;
        mem_wr_en  = 1'b0;
        ok_next    = 1'b0;
        sx_next    = '0;
        sy_next    = '0;
        st_next    = '0;
        shf_next   = 1'b0;
        svf_next   = 1'b0;

        case (state_reg)
            sas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sas_pkg::ST_EXEC;
                end
            end
            sas_pkg::ST_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = sas_pkg::ST_IDLE;
                    case (op_reg)
                        sas_pkg::OP_CLEAR:
                        begin
                            total_next = '0;
                            cur_next   = '0;
                            tick_next  = '0;
                            done_next  = 1'b0;
                            ok_next    = 1'b1;
                        end
                        sas_pkg::OP_ADD:
                        begin
                            if (total_reg < CNT_W'(MAX_FRAMES) && dur_reg != 8'd0 &&
                                tile_reg <= sas_pkg::TILE_LIMIT)
                            begin
                                mem_wr_en  = 1'b1;
                                total_next = total_reg + CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        sas_pkg::OP_STEP:
                        begin
                            if (total_reg != '0 && !done_reg)
                            begin
                                ok_next = 1'b1;
                                if (tick_inc < mem_rd_data.duration)
                                begin
                                    tick_next = tick_inc;
                                end
                                else
                                begin
                                    tick_next = '0;
                                    if (cur_inc < total_reg)
                                    begin
                                        cur_next = IDX_W'(cur_inc);
                                    end
                                    else if (loop_mode_reg)
                                    begin
                                        cur_next = '0;
                                    end
                                    else
                                    begin
                                        done_next = 1'b1;
                                    end
                                end
                            end
                        end
                        sas_pkg::OP_APPLY:
                        begin
                            if (total_reg != '0 && CNT_W'(cur_reg) < total_reg)
                            begin
                                ok_next  = 1'b1;
                                sx_next  = bx_reg + {{8{mem_rd_data.xoff[7]}},
                                                     mem_rd_data.xoff};
                                sy_next  = by_reg + mem_rd_data.yoff;
                                st_next  = mem_rd_data.tile;
                                shf_next = bh_reg ^ mem_rd_data.hflip;
                                svf_next = bv_reg ^ mem_rd_data.vflip;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = sas_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign sprite_x      = sx_reg;
    assign sprite_y      = sy_reg;
    assign sprite_tile   = st_reg;
    assign sprite_hflip  = shf_reg;
    assign sprite_vflip  = svf_reg;
    assign finished_flag = fin_reg;

endmodule
`default_nettype wire

// ----- design/sprite_animation_sequencer_top.sv -----
// Sprite animation sequencer top level: frame table memory plus control core
//
// Holds a table of up to MAX_FRAMES animation frames and runs one operation per
// input transfer (clear, add frame, step one tick, apply to base sprite), giving
// one result transfer per operation. The frame table read at the current frame
// index is issued when the input is taken; the registered read data is used in
// the EXEC state, where state is updated and the result is loaded into the
// output register once that register is empty or draining. No new input is
// taken until then. loop_mode is written through cfg_we/cfg_wdata; the user
// must write it while the block is idle; the block itself does not enforce this.
`default_nettype none
module sprite_animation_sequencer_top #(
    parameter int MAX_FRAMES = sas_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [7:0]           frame_duration,
    input  wire logic [9:0]           frame_tile,
    input  wire logic signed [7:0]    frame_x_offset,
    input  wire logic signed [7:0]    frame_y_offset,
    input  wire logic                 frame_hflip,
    input  wire logic                 frame_vflip,
    input  wire logic signed [15:0]   base_x,
    input  wire logic [7:0]           base_y,
    input  wire logic                 base_hflip,
    input  wire logic                 base_vflip,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      ok,
    output logic signed [15:0]        sprite_x,
    output logic [7:0]                sprite_y,
    output logic [8:0]                sprite_tile,
    output logic                      sprite_hflip,
    output logic                      sprite_vflip,
    output logic                      finished_flag
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    sas_pkg::frame_entry_t mem_rd_data;
    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    sas_pkg::frame_entry_t mem_wr_data;

    sas_frame_mem #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    sas_core #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .frame_duration (frame_duration),
        .frame_tile     (frame_tile),
        .frame_x_offset (frame_x_offset),
        .frame_y_offset (frame_y_offset),
        .frame_hflip    (frame_hflip),
        .frame_vflip    (frame_vflip),
        .base_x         (base_x),
        .base_y         (base_y),
        .base_hflip     (base_hflip),
        .base_vflip     (base_vflip),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .sprite_x       (sprite_x),
        .sprite_y       (sprite_y),
        .sprite_tile    (sprite_tile),
        .sprite_hflip   (sprite_hflip),
        .sprite_vflip   (sprite_vflip),
        .finished_flag  (finished_flag),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data)
    );

endmodule
`default_nettype wire

// ----- test/sprite_animation_sequencer_top_tb.sv -----
// Self-checking testbench for the sprite animation sequencer top level
module sprite_animation_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES   = sas_pkg::MAX_FRAMES_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PLAN_ROWS    = 25;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        sas_pkg::op_t op;
        logic [7:0]  dur;
        logic [9:0]  tile;
        logic [7:0]  xoff;
        logic [7:0]  yoff;
        logic        hf;
        logic        vf;
        logic [15:0] bx;
        logic [7:0]  by;
        logic        bh;
        logic        bv;
    } anim_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] x;
        logic [7:0]  y;
        logic [8:0]  tile;
        logic        hf;
        logic        vf;
        logic        fin;
    } sprite_res_t;

    typedef struct packed {
        logic        cfg_set;
        logic        cfg_val;
        anim_cmd_t   cmd;
        logic        has_exp;
        sprite_res_t exp;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         operation = '0;
    logic [7:0]         frame_duration = '0;
    logic [9:0]         frame_tile = '0;
    logic signed [7:0]  frame_x_offset = '0;
    logic signed [7:0]  frame_y_offset = '0;
    logic               frame_hflip = 1'b0;
    logic               frame_vflip = 1'b0;
    logic signed [15:0] base_x = '0;
    logic [7:0]         base_y = '0;
    logic               base_hflip = 1'b0;
    logic               base_vflip = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               ok;
    logic signed [15:0] sprite_x;
    logic [7:0]         sprite_y;
    logic [8:0]         sprite_tile;
    logic               sprite_hflip;
    logic               sprite_vflip;
    logic               finished_flag;

    // predictor state
    sas_pkg::frame_entry_t frame_store [NUM_FRAMES];
    int           frames_held = 0;
    int           cur_frame = 0;
    logic [7:0]   ticks = '0;
    logic         anim_done = 1'b0;
    logic         loop_on = 1'b0;

    sprite_res_t  results_due [$];
    int           mismatches = 0;
    int           sent_total = 0;
    int           quiet_cycles = 0;
    int           hold_left = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;

    sprite_res_t  want;
    logic [15:0]  want_f [7];
    logic [15:0]  got_f [7];
    string        field_name [7] = '{"ok", "sprite_x", "sprite_y", "sprite_tile",
                                     "sprite_hflip", "sprite_vflip", "finished_flag"};
    int           k;

    sprite_animation_sequencer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .frame_duration(frame_duration),
        .frame_tile    (frame_tile),
        .frame_x_offset(frame_x_offset),
        .frame_y_offset(frame_y_offset),
        .frame_hflip   (frame_hflip),
        .frame_vflip   (frame_vflip),
        .base_x        (base_x),
        .base_y        (base_y),
        .base_hflip    (base_hflip),
        .base_vflip    (base_vflip),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .sprite_x      (sprite_x),
        .sprite_y      (sprite_y),
        .sprite_tile   (sprite_tile),
        .sprite_hflip  (sprite_hflip),
        .sprite_vflip  (sprite_vflip),
        .finished_flag (finished_flag)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic sprite_res_t compute_sprite_result(input anim_cmd_t c);
        sprite_res_t  r;
        sas_pkg::frame_entry_t e;
        r = '0;
        case (c.op)
            sas_pkg::OP_CLEAR:
            begin
                frames_held = 0;
                cur_frame   = 0;
                ticks       = '0;
                anim_done   = 1'b0;
                r.ok        = 1'b1;
            end
            sas_pkg::OP_ADD:
            begin
                if (frames_held < NUM_FRAMES && c.dur != 0 && c.tile <= sas_pkg::TILE_LIMIT)
                begin
                    frame_store[frames_held] = '{c.dur, c.tile[8:0], c.xoff, c.yoff,
                                                 c.hf, c.vf};
                    frames_held++;
                    r.ok = 1'b1;
                end
            end
            sas_pkg::OP_STEP:
            begin
                if (frames_held != 0 && !anim_done)
                begin
                    ticks = ticks + 8'd1;
                    if (ticks >= frame_store[cur_frame].duration)
                    begin
                        ticks = '0;
                        if (cur_frame + 1 < frames_held)
                            cur_frame++;
                        else if (loop_on)
                            cur_frame = 0;
                        else
                            anim_done = 1'b1;
                    end
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                if (frames_held != 0 && cur_frame < frames_held)
                begin
                    e      = frame_store[cur_frame];
                    r.x    = c.bx + {{8{e.xoff[7]}}, e.xoff};
                    r.y    = c.by + e.yoff;
                    r.tile = e.tile;
                    r.hf   = c.bh ^ e.hflip;
                    r.vf   = c.bv ^ e.vflip;
                    r.ok   = 1'b1;
                end
            end
        endcase
        r.fin = anim_done;
        return r;
    endfunction

    function automatic anim_cmd_t cmd_of(input sas_pkg::op_t op, input int dur,
                                         input int tile, input int xo, input int yo,
                                         input bit hf, input bit vf, input int bx,
                                         input int by, input bit bh, input bit bv);
        anim_cmd_t c;
        c = '{op, 8'(dur), 10'(tile), 8'(xo), 8'(yo), hf, vf, 16'(bx), 8'(by), bh, bv};
        return c;
    endfunction

    function automatic plan_row_t row(input bit cs, input bit cv, input anim_cmd_t c,
                                      input bit he, input bit exp_ok, input bit exp_fin);
        plan_row_t p;
        p         = '0;
        p.cfg_set = cs;
        p.cfg_val = cv;
        p.cmd     = c;
        p.has_exp = he;
        p.exp.ok  = exp_ok;
        p.exp.fin = exp_fin;
        return p;
    endfunction

    function automatic anim_cmd_t rand_cmd(input sas_pkg::op_t op);
        anim_cmd_t c;
        c.op   = op;
        c.dur  = 8'($urandom);
        c.tile = 10'($urandom);
        c.xoff = 8'($urandom);
        c.yoff = 8'($urandom);
        c.hf   = 1'($urandom);
        c.vf   = 1'($urandom);
        c.bx   = 16'($urandom);
        c.by   = 8'($urandom);
        c.bh   = 1'($urandom);
        c.bv   = 1'($urandom);
        return c;
    endfunction

    task automatic send_cmd(input anim_cmd_t c, input bit typed, input sprite_res_t typed_res);
        sprite_res_t predicted;
        while (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= c.op;
        frame_duration <= c.dur;
        frame_tile     <= c.tile;
        frame_x_offset <= c.xoff;
        frame_y_offset <= c.yoff;
        frame_hflip    <= c.hf;
        frame_vflip    <= c.vf;
        base_x         <= c.bx;
        base_y         <= c.by;
        base_hflip     <= c.bh;
        base_vflip     <= c.bv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = compute_sprite_result(c);
        results_due.push_back(typed ? typed_res : predicted);
        sent_total++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_loop_mode(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        loop_on  = v;
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected", $time);
                mismatches++;
            end
            else
            begin
                want   = results_due.pop_front();
                want_f = '{16'(want.ok), want.x, 16'(want.y), 16'(want.tile),
                           16'(want.hf), 16'(want.vf), 16'(want.fin)};
                got_f  = '{16'(ok), sprite_x, 16'(sprite_y), 16'(sprite_tile),
                           16'(sprite_hflip), 16'(sprite_vflip), 16'(finished_flag)};
                for (k = 0; k < 7; k++)
                begin
                    if (got_f[k] !== want_f[k])
                    begin
                        $display("%0t: %s expected %0h got %0h", $time, field_name[k],
                                 want_f[k], got_f[k]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("** sprite_animation_sequencer_top: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t plan [PLAN_ROWS];
        anim_cmd_t c;
        int        i;
        int        n;
        int        roll;
        int        next_cfg;
        bit        hold_done;
        bit        pause_done;

        plan = '{
            row(1, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_APPLY, 0, 0, 0, 0, 0, 0, -32768, 255, 1, 1), 1, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 10, 1023, -128, 0, 1, 1, 0, 0, 0, 0), 1, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 10, 512, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 1, 511, 127, 127, 1, 1, 0, 0, 0, 0), 1, 1, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 255, 0, -128, -128, 0, 0, 0, 0, 0, 0), 1, 1, 0),
            row(0, 0, cmd_of(sas_pkg::OP_APPLY, 0, 0, 0, 0, 0, 0, 32767, 255, 1, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_APPLY, 0, 0, 0, 0, 0, 0, -32768, 0, 1, 1), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_CLEAR, 255, 1023, -1, -1, 1, 1, -1, 255, 1, 1),
                1, 1, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 1, 5, 3, -3, 0, 1, 0, 0, 0, 0), 1, 1, 0),
            row(0, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1),
            row(0, 0, cmd_of(sas_pkg::OP_APPLY, 0, 0, 0, 0, 0, 0, 100, 200, 0, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 3, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, 1),
            row(0, 0, cmd_of(sas_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, 0),
            row(1, 1, cmd_of(sas_pkg::OP_ADD, 1, 3, 1, 1, 0, 0, 0, 0, 0, 0), 1, 1, 0),
            row(0, 0, cmd_of(sas_pkg::OP_ADD, 2, 400, -1, 5, 1, 0, 0, 0, 0, 0), 1, 1, 0),
            row(0, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_APPLY, 0, 0, 0, 0, 0, 0, 5, 250, 1, 1), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0),
            row(0, 0, cmd_of(sas_pkg::OP_APPLY, 0, 0, 0, 0, 0, 0, -1, 7, 0, 1), 0, 0, 0)
        };
        next_cfg   = PLAN_ROWS + 300;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].cfg_set)
            begin
                wait_idle();
                set_loop_mode(plan[i].cfg_val);
            end
            send_cmd(plan[i].cmd, plan[i].has_exp, plan[i].exp);
        end

        while (sent_total < PLAN_ROWS + RANDOM_ITEMS)
        begin
            calm = (sent_total >= PLAN_ROWS + 250) && (sent_total < PLAN_ROWS + 450);
            if (sent_total >= next_cfg)
            begin
                wait_idle();
                set_loop_mode(!loop_on);
                next_cfg += 300;
            end
            if (!hold_done && sent_total >= PLAN_ROWS + 700)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent_total >= PLAN_ROWS + 950)
            begin
                wait_idle();
                pause_done = 1'b1;
            end

            if ($urandom_range(99) < 80)
            begin
                // animation run: clear, fill the table (some adds invalid or excess), then run it
                send_cmd(rand_cmd(sas_pkg::OP_CLEAR), 1'b0, '0);
                n = ($urandom_range(99) < 15) ? $urandom_range(17, 20) : $urandom_range(1, 16);
                for (i = 0; i < n; i++)
                begin
                    c         = rand_cmd(sas_pkg::OP_ADD);
                    c.tile[9] = ($urandom_range(99) < 8);
                    roll      = $urandom_range(99);
                    c.dur     = (roll < 5) ? 8'd0 :
                                (roll < 8) ? 8'd255 : 8'($urandom_range(1, 4));
                    send_cmd(c, 1'b0, '0);
                end
                n = $urandom_range(10, 60);
                for (i = 0; i < n; i++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 55)
                        c = rand_cmd(sas_pkg::OP_STEP);
                    else if (roll < 92)
                        c = rand_cmd(sas_pkg::OP_APPLY);
                    else
                    begin
                        c         = rand_cmd(sas_pkg::OP_ADD);
                        c.dur     = 8'($urandom_range(1, 4));
                        c.tile[9] = 1'b0;
                    end
                    send_cmd(c, 1'b0, '0);
                end
            end
            else
            begin
                for (i = 0; i < 8; i++)
                    send_cmd(rand_cmd(sas_pkg::op_t'($urandom_range(3))), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (6) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("** sprite_animation_sequencer_top: PASSED **");
        else
            $display("** sprite_animation_sequencer_top: FAILED **");
        $finish;
    end

endmodule

// ----- sprite_animation_sequencer_top.f -----
design/sas_pkg.sv
design/sas_frame_mem.sv
design/sas_core.sv
design/sprite_animation_sequencer_top.sv
test/sprite_animation_sequencer_top_tb.sv
